@@ src/triangle_tangent_basis_top_assert.svh @@
// Assertion macros used by the port-level checker of the tangent basis block.
`ifndef TRIANGLE_TANGENT_BASIS_TOP_ASSERT_SVH
`define TRIANGLE_TANGENT_BASIS_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ttb_pkg.sv @@
// Types and constants shared by the tangent basis block.
package ttb_pkg;

  localparam int IDX_W   = 10;
  localparam int DATA_W  = 32;
  localparam int QW      = 32;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TRI   = 1'b1;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh80000000;

  typedef struct packed {
    logic                     op;
    logic [IDX_W-1:0]         vertex_index;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] tex_u;
    logic signed [DATA_W-1:0] tex_v;
    logic [IDX_W-1:0]         corner_a;
    logic [IDX_W-1:0]         corner_b;
    logic [IDX_W-1:0]         corner_c;
  } ttb_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] tangent_x;
    logic signed [DATA_W-1:0] tangent_y;
    logic signed [DATA_W-1:0] tangent_z;
    logic signed [DATA_W-1:0] bitangent_x;
    logic signed [DATA_W-1:0] bitangent_y;
    logic signed [DATA_W-1:0] bitangent_z;
    logic                     degenerate;
    logic                     clipped;
  } ttb_result_t;

  typedef enum logic {
    KIND_WRITE,
    KIND_TRI
  } ttb_kind_e;

  typedef struct packed {
    ttb_kind_e kind;
    ttb_item_t item;
  } ttb_entry_t;

  typedef struct packed {
    logic       valid;
    ttb_entry_t entry;
  } ttb_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ttb_qstat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DELTA,
    ST_MUL,
    ST_ABS,
    ST_LIM,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } ttb_state_e;

endpackage

@@ src/ttb_front.sv @@
// Front end: accepts items, drops writes outside the store and tags the rest.
module ttb_front #(
  parameter int VERTEX_DEPTH = 1024
) (
  input  logic               start_i,
  input  ttb_pkg::ttb_item_t item_i,
  input  ttb_pkg::ttb_qstat_t qstat_i,
  output logic               busy_o,
  output ttb_pkg::ttb_push_t push_o
);
  import ttb_pkg::*;

  logic accept;
  logic in_range;

  assign busy_o   = qstat_i.full;
  assign accept   = start_i && !qstat_i.full;
  assign in_range = 32'(item_i.vertex_index) < 32'(VERTEX_DEPTH);

  always_comb begin
    push_o.entry.item = item_i;
    push_o.entry.kind = (item_i.op == OP_TRI) ? KIND_TRI : KIND_WRITE;
    push_o.valid      = accept && ((item_i.op == OP_TRI) || in_range);
  end

endmodule

@@ src/ttb_queue.sv @@
// Short queue of tagged items between the front end and the back end.
module ttb_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ttb_pkg::ttb_push_t  push_i,
  input  logic                pop_i,
  output ttb_pkg::ttb_entry_t head_o,
  output ttb_pkg::ttb_qstat_t qstat_o
);
  import ttb_pkg::*;

  ttb_entry_t           slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [Q_PTR_W:0]     count_q, count_d;

  assign head_o        = slot_q[rd_ptr_q];
  assign qstat_o.full  = count_q == (Q_PTR_W + 1)'(Q_DEPTH);
  assign qstat_o.empty = count_q == '0;

  always_comb begin
    wr_ptr_d = push_i.valid ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (Q_PTR_W + 1)'(push_i.valid) - (Q_PTR_W + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slot_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

@@ src/ttb_div_lane.sv @@
// One restoring divider lane giving a saturated signed fixed-point quotient.
module ttb_div_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     load_i,
  input  logic                     step_i,
  input  logic [63:0]              mag_i,
  input  logic [63:0]              md_i,
  input  logic [95-FRAC_BITS:0]    lim_i,
  input  logic                     neg_i,
  output logic signed [31:0]       value_o,
  output logic                     sat_o
);
  import ttb_pkg::*;

  localparam int LW = 96 - FRAC_BITS;

  logic [63:0]   rem_q;
  logic [QW-1:0] low_q;
  logic [QW-1:0] quo_q;
  logic          ovf_q;
  logic          neg_q;
  logic [64:0]   trial;
  logic          ge;

  assign trial = {rem_q, low_q[QW-1]};
  assign ge    = trial >= {1'b0, md_i};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= mag_i >> (QW - FRAC_BITS);
      low_q <= QW'(mag_i << FRAC_BITS);
      quo_q <= '0;
      ovf_q <= LW'(mag_i) >= lim_i;
      neg_q <= neg_i;
    end else if (step_i) begin
      rem_q <= ge ? 64'(trial - {1'b0, md_i}) : trial[63:0];
      quo_q <= {quo_q[QW-2:0], ge};
      low_q <= {low_q[QW-2:0], 1'b0};
    end
  end

  always_comb begin
    sat_o   = 1'b0;
    value_o = $signed(quo_q);
    if (ovf_q) begin
      sat_o   = 1'b1;
      value_o = neg_q ? SAT_MIN : SAT_MAX;
    end else if (neg_q) begin
      if (quo_q > QW'(SAT_MIN)) begin
        sat_o   = 1'b1;
        value_o = SAT_MIN;
      end else begin
        value_o = $signed(QW'(-quo_q));
      end
    end else if (quo_q[QW-1]) begin
      sat_o   = 1'b1;
      value_o = SAT_MAX;
    end
  end

endmodule

@@ src/ttb_back.sv @@
// Back end: vertex store, edge and UV deltas, shared multiplier and dividers.
module ttb_back #(
  parameter int VERTEX_DEPTH = 1024,
  parameter int FRAC_BITS    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ttb_pkg::ttb_entry_t  head_i,
  input  ttb_pkg::ttb_qstat_t  qstat_i,
  output logic                 pop_o,
  output ttb_pkg::ttb_result_t result_o,
  output logic                 res_valid_o
);
  import ttb_pkg::*;

  localparam int AW       = $clog2(VERTEX_DEPTH);
  localparam int LW       = 96 - FRAC_BITS;
  localparam int LIM_SH   = 31 - FRAC_BITS;
  localparam logic [4:0] RD_LAST  = 5'd3;
  localparam logic [4:0] MUL_LAST = 5'd14;
  localparam logic [4:0] DIV_LAST = 5'(QW - 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] pz;
    logic signed [DATA_W-1:0] u;
    logic signed [DATA_W-1:0] v;
  } ttb_vtx_t;

  function automatic logic [DATA_W:0] sat_sub(logic signed [DATA_W-1:0] a,
                                              logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] d;
    d = (DATA_W + 1)'(a) - (DATA_W + 1)'(b);
    if (d[DATA_W] != d[DATA_W-1]) begin
      return {1'b1, d[DATA_W] ? SAT_MIN : SAT_MAX};
    end
    return {1'b0, d[DATA_W-1:0]};
  endfunction

  ttb_state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  logic mem_we, lane_load, lane_step, res_valid_d;

  ttb_vtx_t mem [VERTEX_DEPTH];
  ttb_vtx_t rd_data_q;
  logic     rd_ok_q;
  logic [AW-1:0] rd_addr;
  logic          rd_ok;
  logic [IDX_W-1:0] corner_q [3];
  logic [IDX_W-1:0] rd_corner;
  ttb_vtx_t vtx_q [3];

  logic [DATA_W:0] sd_d1u, sd_d1v, sd_d2u, sd_d2v;
  logic [DATA_W:0] sd_e1 [3];
  logic [DATA_W:0] sd_e2 [3];

  logic signed [DATA_W-1:0] e1_q [3];
  logic signed [DATA_W-1:0] e2_q [3];
  logic signed [DATA_W-1:0] d1u_q, d1v_q, d2u_q, d2v_q;
  logic                     clip_q;

  logic [3:0]               pair;
  logic [1:0]               kk;
  logic [3:0]               acc_j;
  logic signed [DATA_W-1:0] op_a, op_b;
  logic signed [63:0]       prod_q, hold_q;
  logic signed [64:0]       num_q [7];

  logic [63:0]   md_q;
  logic [63:0]   mag_q [6];
  logic          neg_q [6];
  logic          deg_q;
  logic [LW-1:0] lim_q;

  logic signed [31:0] lane_val [6];
  logic               lane_sat [6];
  logic               any_sat;
  ttb_result_t        result_q;
  logic               res_valid_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!qstat_i.empty && head_i.kind == KIND_TRI) state_d = ST_READ;
      end
      ST_READ:  if (cnt_q == RD_LAST) state_d = ST_DELTA;
      ST_DELTA: state_d = ST_MUL;
      ST_MUL:   if (cnt_q == MUL_LAST) state_d = ST_ABS;
      ST_ABS:   state_d = (num_q[0] == '0) ? ST_FIN : ST_LIM;
      ST_LIM:   state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_DIV;
      ST_DIV:   if (cnt_q == DIV_LAST) state_d = ST_FIN;
      ST_FIN:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
    cnt_d = (state_d != state_q) ? '0 : cnt_q + 5'd1;
  end

  // Control outputs.
  always_comb begin
    pop_o       = (state_q == ST_IDLE) && !qstat_i.empty;
    mem_we      = pop_o && head_i.kind == KIND_WRITE;
    lane_load   = state_q == ST_LOAD;
    lane_step   = state_q == ST_DIV;
    res_valid_d = state_q == ST_FIN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_ok_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_ok_q     <= rd_ok;
      res_valid_q <= res_valid_d;
    end
  end

  always_comb begin
    if (cnt_q == 5'd0) begin
      rd_corner = corner_q[0];
    end else if (cnt_q == 5'd1) begin
      rd_corner = corner_q[1];
    end else begin
      rd_corner = corner_q[2];
    end
    rd_addr = AW'(rd_corner);
    rd_ok   = 32'(rd_corner) < 32'(VERTEX_DEPTH);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[AW'(head_i.item.vertex_index)] <= '{px: head_i.item.pos_x,
                                              py: head_i.item.pos_y,
                                              pz: head_i.item.pos_z,
                                              u:  head_i.item.tex_u,
                                              v:  head_i.item.tex_v};
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    sd_d1u   = sat_sub(vtx_q[1].u, vtx_q[0].u);
    sd_d1v   = sat_sub(vtx_q[1].v, vtx_q[0].v);
    sd_d2u   = sat_sub(vtx_q[2].u, vtx_q[0].u);
    sd_d2v   = sat_sub(vtx_q[2].v, vtx_q[0].v);
    sd_e1[0] = sat_sub(vtx_q[1].px, vtx_q[0].px);
    sd_e1[1] = sat_sub(vtx_q[1].py, vtx_q[0].py);
    sd_e1[2] = sat_sub(vtx_q[1].pz, vtx_q[0].pz);
    sd_e2[0] = sat_sub(vtx_q[2].px, vtx_q[0].px);
    sd_e2[1] = sat_sub(vtx_q[2].py, vtx_q[0].py);
    sd_e2[2] = sat_sub(vtx_q[2].pz, vtx_q[0].pz);
  end

  always_comb begin
    pair  = cnt_q[4:1];
    kk    = (pair <= 4'd3) ? 2'(pair - 4'd1) : 2'(pair - 4'd4);
    acc_j = 4'(cnt_q - 5'd1);
    op_a  = d1u_q;
    op_b  = d2v_q;
    if (pair == 4'd0) begin
      op_a = cnt_q[0] ? d2u_q : d1u_q;
      op_b = cnt_q[0] ? d1v_q : d2v_q;
    end else if (pair <= 4'd3) begin
      op_a = cnt_q[0] ? d1v_q : d2v_q;
      op_b = cnt_q[0] ? e2_q[kk] : e1_q[kk];
    end else begin
      op_a = cnt_q[0] ? d2u_q : d1u_q;
      op_b = cnt_q[0] ? e1_q[kk] : e2_q[kk];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.kind == KIND_TRI) begin
      corner_q[0] <= head_i.item.corner_a;
      corner_q[1] <= head_i.item.corner_b;
      corner_q[2] <= head_i.item.corner_c;
    end
    if (state_q == ST_READ && cnt_q != 5'd0) begin
      vtx_q[2'(cnt_q - 5'd1)] <= rd_ok_q ? rd_data_q : '0;
    end
    if (state_q == ST_DELTA) begin
      d1u_q   <= sd_d1u[DATA_W-1:0];
      d1v_q   <= sd_d1v[DATA_W-1:0];
      d2u_q   <= sd_d2u[DATA_W-1:0];
      d2v_q   <= sd_d2v[DATA_W-1:0];
      e1_q[0] <= sd_e1[0][DATA_W-1:0];
      e1_q[1] <= sd_e1[1][DATA_W-1:0];
      e1_q[2] <= sd_e1[2][DATA_W-1:0];
      e2_q[0] <= sd_e2[0][DATA_W-1:0];
      e2_q[1] <= sd_e2[1][DATA_W-1:0];
      e2_q[2] <= sd_e2[2][DATA_W-1:0];
      clip_q  <= sd_d1u[DATA_W] | sd_d1v[DATA_W] | sd_d2u[DATA_W] | sd_d2v[DATA_W]
               | sd_e1[0][DATA_W] | sd_e1[1][DATA_W] | sd_e1[2][DATA_W]
               | sd_e2[0][DATA_W] | sd_e2[1][DATA_W] | sd_e2[2][DATA_W];
    end
    if (state_q == ST_MUL) begin
      if (cnt_q != MUL_LAST) begin
        prod_q <= op_a * op_b;
      end
      if (cnt_q != 5'd0) begin
        if (!acc_j[0]) begin
          hold_q <= prod_q;
        end else begin
          num_q[acc_j[3:1]] <= 65'(hold_q) - 65'(prod_q);
        end
      end
    end
    if (state_q == ST_ABS) begin
      deg_q <= num_q[0] == '0;
      md_q  <= 64'(num_q[0][64] ? -num_q[0] : num_q[0]);
      for (int i = 0; i < 6; i++) begin
        mag_q[i] <= 64'(num_q[i+1][64] ? -num_q[i+1] : num_q[i+1]);
        neg_q[i] <= num_q[i+1][64] ^ num_q[0][64];
      end
    end
    if (state_q == ST_LIM) begin
      lim_q <= (LW'(md_q) << LIM_SH) + LW'(md_q);
    end
    if (state_q == ST_FIN) begin
      if (deg_q) begin
        result_q            <= '0;
        result_q.degenerate <= 1'b1;
      end else begin
        result_q.tangent_x   <= lane_val[0];
        result_q.tangent_y   <= lane_val[1];
        result_q.tangent_z   <= lane_val[2];
        result_q.bitangent_x <= lane_val[3];
        result_q.bitangent_y <= lane_val[4];
        result_q.bitangent_z <= lane_val[5];
        result_q.degenerate  <= 1'b0;
        result_q.clipped     <= clip_q | any_sat;
      end
    end
  end

  for (genvar g = 0; g < 6; g++) begin : g_lane
    ttb_div_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .load_i (lane_load),
      .step_i (lane_step),
      .mag_i  (mag_q[g]),
      .md_i   (md_q),
      .lim_i  (lim_q),
      .neg_i  (neg_q[g]),
      .value_o(lane_val[g]),
      .sat_o  (lane_sat[g])
    );
  end

  assign any_sat = lane_sat[0] | lane_sat[1] | lane_sat[2]
                 | lane_sat[3] | lane_sat[4] | lane_sat[5];

  assign result_o    = result_q;
  assign res_valid_o = res_valid_q;

endmodule

@@ src/triangle_tangent_basis_top.sv @@
// Top level of the triangle tangent and bitangent block.
//
// An item is taken at a rising edge with start high and busy low. A write item
// (op low) stores one vertex at vertex_index if it lies inside the store; it
// gives no result and the back end retires it when it pops it. A triangle item
// (op high) reads corners a, b and c and gives one result on result_o, marked
// by res_valid_o for exactly one cycle. In the back end a triangle passes the
// three corner reads through the single store read port, the shared 32x32
// multiplier and the six bit-serial divider lanes that run in parallel.
// A degenerate triangle skips the divide and its result comes sooner.
// A two-entry queue lets items be taken while the back end works; busy rises
// when it is full. The user must take a result when it is shown; the block
// itself does not enforce it.
// Reset clears the queue and control state; store contents stay undefined
// until written, and no clearing pass runs.
module triangle_tangent_basis_top #(
  parameter int VERTEX_DEPTH = 1024,
  parameter int FRAC_BITS    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  ttb_pkg::ttb_item_t   item_i,
  output logic                 busy,
  output ttb_pkg::ttb_result_t result_o,
  output logic                 res_valid_o
);
  import ttb_pkg::*;

  ttb_push_t  push;
  ttb_entry_t head;
  ttb_qstat_t qstat;
  logic       pop;

  ttb_front #(
    .VERTEX_DEPTH(VERTEX_DEPTH)
  ) u_front (
    .start_i(start),
    .item_i (item_i),
    .qstat_i(qstat),
    .busy_o (busy),
    .push_o (push)
  );

  ttb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .qstat_o(qstat)
  );

  ttb_back #(
    .VERTEX_DEPTH(VERTEX_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .qstat_i    (qstat),
    .pop_o      (pop),
    .result_o   (result_o),
    .res_valid_o(res_valid_o)
  );

endmodule

@@ src/ttb_checker.sv @@
// Port-level checks of the tangent basis block and their binding.
`include "triangle_tangent_basis_top_assert.svh"

module ttb_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input ttb_pkg::ttb_item_t   item_i,
  input logic                 busy,
  input ttb_pkg::ttb_result_t result_o,
  input logic                 res_valid_o
);
  import ttb_pkg::*;

  logic deg_zero;

  assign deg_zero = result_o.tangent_x == '0 && result_o.tangent_y == '0
                 && result_o.tangent_z == '0 && result_o.bitangent_x == '0
                 && result_o.bitangent_y == '0 && result_o.bitangent_z == '0
                 && !result_o.clipped;

  `TTB_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, res_valid_o, !res_valid_o, "result strobe repeated")
  `TTB_ASSERT_IMP(a_strobe_spacing, clk_i, rst_ni, res_valid_o, !$past(res_valid_o, 2), "results too close")
  `TTB_ASSERT_IMP(a_degenerate_zero, clk_i, rst_ni, res_valid_o && result_o.degenerate, deg_zero, "degenerate result not zero")

endmodule

bind triangle_tangent_basis_top ttb_checker u_ttb_checker (.*);

@@ verif/triangle_tangent_basis_checker.sv @@
// Checker that predicts tangent basis results from accepted items and compares them.
`timescale 1ns / 100ps
module triangle_tangent_basis_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  ttb_pkg::ttb_item_t   item_i,
  input  logic                 res_valid_i,
  input  ttb_pkg::ttb_result_t result_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  import ttb_pkg::*;

  localparam int DEPTH = 1024;
  localparam int FRAC = 16;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  logic signed [31:0] px_mem [DEPTH];
  logic signed [31:0] py_mem [DEPTH];
  logic signed [31:0] pz_mem [DEPTH];
  logic signed [31:0] u_mem [DEPTH];
  logic signed [31:0] v_mem [DEPTH];
  ttb_result_t basis_q[$];
  int fails = 0;

  assign fail_count_o = fails;
  assign pending_o = basis_q.size();

  function automatic longint clamp_diff(longint a, longint b, ref bit clip);
    longint d;
    d = a - b;
    if (d > S32_MAX) begin
      clip = 1;
      return S32_MAX;
    end
    if (d < S32_MIN) begin
      clip = 1;
      return S32_MIN;
    end
    return d;
  endfunction

  function automatic logic [31:0] q_divide(longint num, longint den, ref bit clip);
    logic [63:0] mn, md, q, rem, r;
    bit neg;
    mn = num < 0 ? 64'd0 - 64'(num) : 64'(num);
    md = den < 0 ? 64'd0 - 64'(den) : 64'(den);
    neg = (num < 0) != (den < 0);
    q = mn / md;
    rem = mn % md;
    if (q > (64'd1 << (31 - FRAC))) begin
      clip = 1;
      return neg ? 32'h80000000 : 32'h7fffffff;
    end
    r = q;
    for (int i = 0; i < FRAC; i++) begin
      rem = rem << 1;
      r = r << 1;
      if (rem >= md) begin
        rem = rem - md;
        r[0] = 1'b1;
      end
    end
    if (neg) begin
      if (r > 64'h80000000) begin
        clip = 1;
        return 32'h80000000;
      end
      return 32'(64'd0 - r);
    end
    if (r > 64'h7fffffff) begin
      clip = 1;
      return 32'h7fffffff;
    end
    return r[31:0];
  endfunction

  function automatic ttb_result_t tangent_basis(ttb_item_t it);
    ttb_result_t res;
    longint p[3][3];
    longint t[3][2];
    longint e1[3], e2[3], d1[2], d2[2], det;
    logic [9:0] idx[3];
    bit clip;
    clip = 0;
    res = '0;
    idx[0] = it.corner_a;
    idx[1] = it.corner_b;
    idx[2] = it.corner_c;
    for (int c = 0; c < 3; c++) begin
      p[c][0] = px_mem[idx[c]];
      p[c][1] = py_mem[idx[c]];
      p[c][2] = pz_mem[idx[c]];
      t[c][0] = u_mem[idx[c]];
      t[c][1] = v_mem[idx[c]];
    end
    for (int k = 0; k < 3; k++) begin
      e1[k] = clamp_diff(p[1][k], p[0][k], clip);
      e2[k] = clamp_diff(p[2][k], p[0][k], clip);
    end
    for (int k = 0; k < 2; k++) begin
      d1[k] = clamp_diff(t[1][k], t[0][k], clip);
      d2[k] = clamp_diff(t[2][k], t[0][k], clip);
    end
    det = d1[0] * d2[1] - d2[0] * d1[1];
    if (det == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    res.tangent_x = q_divide(d2[1] * e1[0] - d1[1] * e2[0], det, clip);
    res.bitangent_x = q_divide(d1[0] * e2[0] - d2[0] * e1[0], det, clip);
    res.tangent_y = q_divide(d2[1] * e1[1] - d1[1] * e2[1], det, clip);
    res.bitangent_y = q_divide(d1[0] * e2[1] - d2[0] * e1[1], det, clip);
    res.tangent_z = q_divide(d2[1] * e1[2] - d1[1] * e2[2], det, clip);
    res.bitangent_z = q_divide(d1[0] * e2[2] - d2[0] * e1[2], det, clip);
    res.clipped = clip;
    return res;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    ttb_result_t exp_r;
    if (rst_ni) begin
      if (res_valid_i) begin
        if (basis_q.size() == 0) begin
          $error("result with no item pending");
          fails++;
        end else begin
          exp_r = basis_q.pop_front();
          compare_field("tangent_x", exp_r.tangent_x, result_i.tangent_x);
          compare_field("tangent_y", exp_r.tangent_y, result_i.tangent_y);
          compare_field("tangent_z", exp_r.tangent_z, result_i.tangent_z);
          compare_field("bitangent_x", exp_r.bitangent_x, result_i.bitangent_x);
          compare_field("bitangent_y", exp_r.bitangent_y, result_i.bitangent_y);
          compare_field("bitangent_z", exp_r.bitangent_z, result_i.bitangent_z);
          compare_field("degenerate", 32'(exp_r.degenerate), 32'(result_i.degenerate));
          compare_field("clipped", 32'(exp_r.clipped), 32'(result_i.clipped));
        end
      end
      if (start_i && !busy_i) begin
        if (item_i.op == OP_WRITE) begin
          px_mem[item_i.vertex_index] = item_i.pos_x;
          py_mem[item_i.vertex_index] = item_i.pos_y;
          pz_mem[item_i.vertex_index] = item_i.pos_z;
          u_mem[item_i.vertex_index] = item_i.tex_u;
          v_mem[item_i.vertex_index] = item_i.tex_v;
        end else begin
          basis_q.push_back(tangent_basis(item_i));
        end
      end
    end
  end
endmodule

@@ verif/triangle_tangent_basis_top_tb.sv @@
// Testbench top that drives vertex and triangle items and gives the verdict.
`timescale 1ns / 100ps
module triangle_tangent_basis_top_tb;
  import ttb_pkg::*;

  localparam longint CYCLE_LIMIT = 1000000;

  logic clk_i, rst_ni, start, busy, res_valid_o;
  ttb_item_t item_i;
  ttb_result_t result_o;
  int fail_count, pending;
  int gap_pct;
  longint cycles;
  bit written[1024];
  logic [9:0] used_q[$];

  triangle_tangent_basis_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .item_i(item_i),
    .busy(busy), .result_o(result_o), .res_valid_o(res_valid_o)
  );

  triangle_tangent_basis_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy), .item_i(item_i),
    .res_valid_i(res_valid_o), .result_i(result_o), .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(0, 8)) - 4) << 16;
      3: return 32'($urandom_range(0, 255)) << 12;
      4: return 32'(int'($urandom_range(0, 2000)) - 1000);
      default: return $urandom();
    endcase
  endfunction

  task automatic send(ttb_item_t it);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (it.op == OP_WRITE && !written[it.vertex_index]) begin
      written[it.vertex_index] = 1;
      used_q.push_back(it.vertex_index);
    end
  endtask

  task automatic write_vertex(logic [9:0] idx, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z, logic [31:0] u, logic [31:0] v);
    ttb_item_t it;
    it = '0;
    it.op = OP_WRITE;
    it.vertex_index = idx;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.tex_u = u;
    it.tex_v = v;
    it.corner_a = 10'($urandom());
    it.corner_b = 10'($urandom());
    it.corner_c = 10'($urandom());
    send(it);
  endtask

  task automatic triangle(logic [9:0] a, logic [9:0] b, logic [9:0] c);
    ttb_item_t it;
    logic [223:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom()};
    it = raw[$bits(ttb_item_t)-1:0];
    it.op = OP_TRI;
    it.corner_a = a;
    it.corner_b = b;
    it.corner_c = c;
    send(it);
  endtask

  function automatic logic [9:0] used_slot();
    return used_q[$urandom_range(0, used_q.size() - 1)];
  endfunction

  initial begin
    int n;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    gap_pct = 38;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_vertex(10'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    write_vertex(10'd1, 32'h00010000, 32'h0, 32'h0, 32'h00010000, 32'h0);
    write_vertex(10'd2, 32'h0, 32'h00010000, 32'h0, 32'h0, 32'h00010000);
    write_vertex(10'd1023, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000);
    write_vertex(10'd512, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000,
                 32'h7fffffff);
    write_vertex(10'd3, 32'h00020000, 32'h00020000, 32'h0, 32'h00020000, 32'h00020000);
    write_vertex(10'd4, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h1, 32'h0);
    write_vertex(10'd5, 32'h80000000, 32'h80000000, 32'h80000000, 32'h0, 32'h1);
    triangle(10'd0, 10'd1, 10'd2);
    triangle(10'd0, 10'd0, 10'd0);
    triangle(10'd0, 10'd1, 10'd3);
    triangle(10'd1023, 10'd512, 10'd0);
    triangle(10'd512, 10'd1023, 10'd1);
    triangle(10'd0, 10'd4, 10'd5);
    triangle(10'd2, 10'd1, 10'd0);
    triangle(10'd1023, 10'd1, 10'd2);
    triangle(10'd5, 10'd4, 10'd3);

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = phase == 0 ? 38 : (phase == 1 ? 50 : 0);
      n = 0;
      while (n < 400) begin
        if ($urandom_range(0, 99) < 45 || used_q.size() < 3) begin
          write_vertex($urandom_range(0, 1) ? 10'($urandom()) : 10'($urandom_range(0, 31)),
                       pick_value(), pick_value(), pick_value(), pick_value(),
                       pick_value());
        end else begin
          triangle(used_slot(), used_slot(), used_slot());
        end
        n++;
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
